// File: rtl/lru_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lru_pkg;

    localparam int IN_DATA_W  = 16;   // page_number
    localparam int CFG_W      = 5;    // frames_in_use
    localparam int EVICT_W    = 16;   // evicted_page field width
    localparam int COUNT_W    = 32;   // fault_count field width
    localparam int OUT_DATA_W = 56;   // 50 bits of fields rounded up to bytes

    // Outcome of one lookup in the frame table.
    typedef struct packed {
        logic               page_fault;
        logic               evicted_valid;
        logic [EVICT_W-1:0] evicted_page;
    } lookup_t;

endpackage

// File: rtl/lru_frame_table.sv
// Fully associative frame table with recency ranks and LRU victim selection.
module lru_frame_table #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int CNT_W     = $clog2(FRAMES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 lk_valid,
    input  logic [PAGE_BITS-1:0] lk_page,
    input  logic                 lk_last,
    input  logic [CNT_W-1:0]     limit,
    output lru_pkg::lookup_t     lk_result
);

    localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int EW     = lru_pkg::EVICT_W;

    logic [PAGE_BITS-1:0] page_reg [FRAMES];
    logic [FRAMES-1:0]    valid_reg;
    logic [FRAMES-1:0]    valid_next;
    logic [RANK_W-1:0]    rank_reg  [FRAMES];
    logic [RANK_W-1:0]    rank_next [FRAMES];
    logic [CNT_W-1:0]     resident_reg;
    logic [CNT_W-1:0]     resident_next;

    logic [FRAMES-1:0]    hit_vec;
    logic [FRAMES-1:0]    lru_vec;
    logic [FRAMES-1:0]    free_vec;
    logic [FRAMES-1:0]    ins_vec;
    logic                 hit_any;
    logic                 evict;
    logic [RANK_W-1:0]    hit_rank;
    logic [RANK_W-1:0]    oldest_rank;
    logic [PAGE_BITS-1:0] ev_page;

    // Valid ranks are always 0..resident-1, so the LRU frame is the one at resident-1.
    assign oldest_rank = RANK_W'(resident_reg - CNT_W'(1));
    assign evict       = !hit_any && (resident_reg >= limit);
    assign ins_vec     = evict ? lru_vec : free_vec;

    always_comb
    begin
        logic found;
        found    = 1'b0;
        hit_rank = '0;
        ev_page  = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            hit_vec[i]  = valid_reg[i] && (page_reg[i] == lk_page);
            lru_vec[i]  = valid_reg[i] && (rank_reg[i] == oldest_rank);
            free_vec[i] = !valid_reg[i] && !found;
            if (!valid_reg[i])
            begin
                found = 1'b1;
            end
            hit_rank = hit_rank | (rank_reg[i] & {RANK_W{hit_vec[i]}});
            ev_page  = ev_page | (page_reg[i] & {PAGE_BITS{lru_vec[i]}});
        end
        hit_any = |hit_vec;
    end

    always_comb
    begin
        lk_result.page_fault    = !hit_any;
        lk_result.evicted_valid = evict;
        lk_result.evicted_page  = evict ? EW'(ev_page) : '0;
    end

    always_comb
    begin
        valid_next    = valid_reg;
        resident_next = resident_reg;
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (lk_last)
        begin
            valid_next    = '0;
            resident_next = '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_next[i] = '0;
            end
        end
        else if (hit_any)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                if (hit_vec[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
        else
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                if (ins_vec[i])
                begin
                    rank_next[i]  = '0;
                    valid_next[i] = 1'b1;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            if (!evict)
            begin
                resident_next = resident_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            resident_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (lk_valid)
        begin
            valid_reg    <= valid_next;
            resident_reg <= resident_next;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Page tags need no reset; a frame is only read while valid.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            if (lk_valid && !hit_any && ins_vec[i])
            begin
                page_reg[i] <= lk_page;
            end
        end
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(resident_reg))
        else $error("resident count does not match valid frames");

    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("page resident in more than one frame");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (lk_valid && lk_last) |=> (valid_reg == '0 && resident_reg == '0))
        else $error("frames not cleared after last reference");

    a_lru_found: assert property (@(posedge clk) disable iff (!rst_n)
        (resident_reg != '0) |-> $onehot(lru_vec))
        else $error("no unique least recently used frame");

endmodule

// File: rtl/lru_page_replacement.sv
// LRU page replacement unit: top level with stream ports and fault counter.
// Flow: an accepted reference is held in the input register; its lookup result is
//   registered into the output register once that is free, then shown on m_tvalid.
// Throughput: one reference per cycle unless m_tready stalls; lookup is combinational.
// Reset: asynchronous, active low; all frames invalid, fault count 0, frames_in_use 16.
// The last reference of a string clears frames and fault count after its result.
module lru_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lru_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] page_number
    input  logic                            s_tlast,   // last_reference
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] page_fault, [1] evicted_valid, [17:2] evicted_page, [49:18] fault_count,
    // [55:50] zero
    output logic [lru_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lru_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int CW     = lru_pkg::COUNT_W;
    localparam int FIELDS = 2 + lru_pkg::EVICT_W + lru_pkg::COUNT_W;
    localparam int PAD_W  = lru_pkg::OUT_DATA_W - FIELDS;

    logic                       in_valid_reg;
    logic [PAGE_BITS-1:0]       in_page_reg;
    logic                       in_last_reg;
    logic                       out_valid_reg;
    logic [lru_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [lru_pkg::CFG_W-1:0]  frames_in_use_reg;
    logic [CW-1:0]              faults_reg;
    logic [CW-1:0]              faults_next;
    logic [CW-1:0]              count_now;
    logic [31:0]                lim_wide;
    logic [CNT_W-1:0]           limit;
    logic                       fire;
    lru_pkg::lookup_t           lk_result;

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Zero acts as one frame, anything above FRAMES as FRAMES.
    always_comb
    begin
        lim_wide = 32'(frames_in_use_reg);
        if (lim_wide == 32'd0)
        begin
            lim_wide = 32'd1;
        end
        else if (lim_wide > 32'(FRAMES))
        begin
            lim_wide = 32'(FRAMES);
        end
        limit = CNT_W'(lim_wide);
    end

    lru_frame_table #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .CNT_W     (CNT_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .lk_valid  (fire),
        .lk_page   (in_page_reg),
        .lk_last   (in_last_reg),
        .limit     (limit),
        .lk_result (lk_result)
    );

    // Saturating fault count; cleared behind the last reference of a string.
    always_comb
    begin
        count_now = faults_reg;
        if (lk_result.page_fault && (faults_reg != {CW{1'b1}}))
        begin
            count_now = faults_reg + CW'(1);
        end
        faults_next = in_last_reg ? '0 : count_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            faults_reg        <= '0;
            frames_in_use_reg <= lru_pkg::CFG_W'(16);
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                faults_reg    <= faults_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                frames_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_page_reg <= PAGE_BITS'(s_tdata);
            in_last_reg <= s_tlast;
        end
        if (fire)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, count_now, lk_result.evicted_page,
                             lk_result.evicted_valid, lk_result.page_fault};
        end
    end

endmodule

// File: sim/tb_lru_page_replacement.sv
// Testbench for lru_page_replacement: directed table plus random reference strings.
`timescale 1ns / 100ps

module tb_lru_page_replacement;

    localparam int NFRAMES   = 16;
    localparam int N_DIRECT  = 25;
    localparam int N_RANDOM  = 1880;
    localparam int TAIL_WAIT = 10;

    typedef enum bit {ROW_REF, ROW_CFG} row_kind_t;

    typedef struct packed {
        bit                        fault;
        bit                        ev_valid;
        bit [lru_pkg::EVICT_W-1:0] ev_page;
        bit [lru_pkg::COUNT_W-1:0] count;
    } outcome_t;

    typedef struct packed {
        row_kind_t                   kind;
        bit [lru_pkg::CFG_W-1:0]     cfg;
        bit [lru_pkg::IN_DATA_W-1:0] page;
        bit                          last;
        bit                          checked;
        outcome_t                    want;
    } step_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [lru_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lru_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [lru_pkg::CFG_W-1:0]       cfg_data = '0;

    // frame table shadow
    bit [lru_pkg::IN_DATA_W-1:0] fr_page [NFRAMES];
    bit                          fr_valid [NFRAMES];
    int unsigned                 fr_rank [NFRAMES];
    int unsigned                 resident;
    bit [lru_pkg::COUNT_W-1:0]   faults;
    bit [lru_pkg::CFG_W-1:0]     frames_cfg;

    outcome_t    pending_results [$];
    int unsigned err_count;
    int unsigned refs_sent, hits_seen, faults_seen, evictions_seen, strings_ended;
    int unsigned limit_writes, results_checked;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;
    int unsigned rx_hold_cycles;

    lru_page_replacement DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_string();
        for (int i = 0; i < NFRAMES; i++)
        begin
            fr_page[i]  = '0;
            fr_valid[i] = 1'b0;
            fr_rank[i]  = 0;
        end
        resident = 0;
        faults   = '0;
    endfunction

    // One reference through the frame table; returns the result it should give.
    function automatic outcome_t lookup_page(bit [lru_pkg::IN_DATA_W-1:0] page, bit last);
        int          hit_at;
        int          slot;
        int unsigned lim;
        int unsigned oldest;
        int unsigned r;
        outcome_t    o;
        hit_at = -1;
        slot   = -1;
        oldest = 0;
        o      = '0;
        lim    = 32'(frames_cfg);
        if (lim < 1)
            lim = 1;
        if (lim > NFRAMES)
            lim = NFRAMES;
        for (int i = 0; i < NFRAMES; i++)
            if (hit_at < 0 && fr_valid[i] && fr_page[i] == page)
                hit_at = i;
        if (hit_at >= 0)
        begin
            r = fr_rank[hit_at];
            for (int i = 0; i < NFRAMES; i++)
                if (fr_valid[i] && fr_rank[i] < r)
                    fr_rank[i]++;
            fr_rank[hit_at] = 0;
        end
        else
        begin
            o.fault = 1'b1;
            if (faults != '1)
                faults++;
            if (resident >= lim)
            begin
                for (int i = 0; i < NFRAMES; i++)
                    if (fr_valid[i] && (slot < 0 || fr_rank[i] > oldest))
                    begin
                        slot   = i;
                        oldest = fr_rank[i];
                    end
                if (slot >= 0)
                begin
                    o.ev_valid     = 1'b1;
                    o.ev_page      = fr_page[slot];
                    fr_valid[slot] = 1'b0;
                    resident--;
                end
            end
            // no eviction: lowest free frame
            if (slot < 0)
                for (int i = 0; i < NFRAMES; i++)
                    if (slot < 0 && !fr_valid[i])
                        slot = i;
            if (slot >= 0)
            begin
                for (int i = 0; i < NFRAMES; i++)
                    if (fr_valid[i])
                        fr_rank[i]++;
                fr_valid[slot] = 1'b1;
                fr_page[slot]  = page;
                fr_rank[slot]  = 0;
                resident++;
            end
        end
        o.count = faults;
        if (last)
            clear_string();
        return o;
    endfunction

    function automatic step_t ref_row(bit [lru_pkg::IN_DATA_W-1:0] page, bit last);
        step_t s;
        s      = '0;
        s.kind = ROW_REF;
        s.page = page;
        s.last = last;
        return s;
    endfunction

    function automatic step_t chk_row(bit [lru_pkg::IN_DATA_W-1:0] page, bit last,
                                      bit fault, bit ev_valid,
                                      bit [lru_pkg::EVICT_W-1:0] ev_page,
                                      bit [lru_pkg::COUNT_W-1:0] count);
        step_t s;
        s                = ref_row(page, last);
        s.checked        = 1'b1;
        s.want.fault     = fault;
        s.want.ev_valid  = ev_valid;
        s.want.ev_page   = ev_page;
        s.want.count     = count;
        return s;
    endfunction

    function automatic step_t cfg_row(bit [lru_pkg::CFG_W-1:0] value);
        step_t s;
        s      = '0;
        s.kind = ROW_CFG;
        s.cfg  = value;
        return s;
    endfunction

    task automatic send_ref(bit [lru_pkg::IN_DATA_W-1:0] page, bit last, bit use_want,
                            outcome_t want);
        int unsigned gap;
        bit          took;
        outcome_t    got;
        gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= page;
        s_tlast  <= last;
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        got = lookup_page(page, last);
        pending_results.push_back(use_want ? want : got);
        refs_sent++;
        if (got.fault)
            faults_seen++;
        else
            hits_seen++;
        if (got.ev_valid)
            evictions_seen++;
        if (last)
            strings_ended++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frames(bit [lru_pkg::CFG_W-1:0] value);
        bit took;
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        cfg_valid  <= 1'b0;
        frames_cfg = value;
        limit_writes++;
    endtask

    task automatic check_result(logic [lru_pkg::OUT_DATA_W-1:0] word);
        outcome_t w;
        results_checked++;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result transfer: m_tdata=%h", word);
            err_count++;
        end
        else
        begin
            w = pending_results.pop_front();
            if (word[0] !== w.fault)
            begin
                $error("page_fault: expected %0d, got %0d", w.fault, word[0]);
                err_count++;
            end
            if (word[1] !== w.ev_valid)
            begin
                $error("evicted_valid: expected %0d, got %0d", w.ev_valid, word[1]);
                err_count++;
            end
            if (word[17:2] !== w.ev_page)
            begin
                $error("evicted_page: expected %h, got %h", w.ev_page, word[17:2]);
                err_count++;
            end
            if (word[49:18] !== w.count)
            begin
                $error("fault_count: expected %0d, got %0d", w.count, word[49:18]);
                err_count++;
            end
            if (word[lru_pkg::OUT_DATA_W-1:50] !== '0)
            begin
                $error("padding: expected 0, got %h", word[lru_pkg::OUT_DATA_W-1:50]);
                err_count++;
            end
        end
    endtask

    // result side: random ready, long hold-off on request, check each transfer
    initial
    begin : result_sink
        int unsigned                     pause;
        bit                              take;
        logic [lru_pkg::OUT_DATA_W-1:0]  word;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (rx_hold_cycles != 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            pause = rx_gaps_on ? $urandom_range(0, 8) : 0;
            if (pause != 0)
            begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                take = m_tvalid;
                word = m_tdata;
                @(posedge clk);
            end
            while (!take);
            check_result(word);
        end
    end

    initial
    begin : run_limit
        #2_000_000;
        $display("** lru_page_replacement: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        step_t                       dir_tab [0:N_DIRECT-1];
        bit [lru_pkg::IN_DATA_W-1:0] pool [24];
        int unsigned                 pool_sz;
        int unsigned                 seg_len;
        int unsigned                 seg;
        int unsigned                 sent_random;
        bit [lru_pkg::IN_DATA_W-1:0] page;
        bit [lru_pkg::CFG_W-1:0]     limit;

        frames_cfg = 5'd16;
        clear_string();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_tab = '{
            chk_row(16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd1),
            chk_row(16'hFFFF, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd2),
            chk_row(16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd2),
            chk_row(16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0000, 32'd2),
            chk_row(16'h0000, 1'b1, 1'b1, 1'b0, 16'h0000, 32'd1),
            cfg_row(5'd1),
            chk_row(16'h1234, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd1),
            chk_row(16'h5678, 1'b0, 1'b1, 1'b1, 16'h1234, 32'd2),
            chk_row(16'h5678, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd2),
            chk_row(16'hA5A5, 1'b1, 1'b1, 1'b1, 16'h5678, 32'd3),
            cfg_row(5'd0),          // zero frames behaves as one
            chk_row(16'h0001, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd1),
            chk_row(16'h0002, 1'b1, 1'b1, 1'b1, 16'h0001, 32'd2),
            cfg_row(5'd31),         // clamps to the frame count
            ref_row(16'h0010, 1'b0),
            ref_row(16'h0011, 1'b0),
            ref_row(16'h0012, 1'b0),
            ref_row(16'h0013, 1'b0),
            ref_row(16'h0010, 1'b0),
            cfg_row(5'd2),          // limit now below the four residents
            ref_row(16'h0020, 1'b0),
            ref_row(16'h0021, 1'b0),
            cfg_row(5'd16),
            ref_row(16'h5A5A, 1'b0),
            ref_row(16'h0012, 1'b1)
        };

        for (int i = 0; i < N_DIRECT; i++)
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_frames(dir_tab[i].cfg);
            else
                send_ref(dir_tab[i].page, dir_tab[i].last, dir_tab[i].checked,
                         dir_tab[i].want);
        end

        // random strings: mostly a small working set so hits and evictions mix
        seg         = 0;
        sent_random = 0;
        while (sent_random < N_RANDOM)
        begin
            case (seg)
                0:       limit = 5'd1;
                1:       limit = 5'd16;
                2:       limit = 5'd31;
                3:       limit = 5'd0;
                default: limit = 5'($urandom_range(0, 31));
            endcase
            write_frames(limit);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            if (seg == 5)
                tx_gaps_on = 1'b0;
            pool_sz = $urandom_range(2, 24);
            for (int i = 0; i < 24; i++)
                pool[i] = 16'($urandom_range(0, 65535));
            seg_len = $urandom_range(60, 180);
            for (int n = 0; n < seg_len && sent_random < N_RANDOM; n++)
            begin
                // stall the result side while references keep coming
                if (seg == 5 && n == 20)
                    rx_hold_cycles = 300;
                if ($urandom_range(0, 9) < 8)
                    page = pool[$urandom_range(0, pool_sz - 1)];
                else
                    page = 16'($urandom_range(0, 65535));
                send_ref(page, ($urandom_range(0, 59) == 0), 1'b0, '0);
                sent_random++;
            end
            seg++;
        end

        drain_results();
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Sent %0d references: %0d hits, %0d faults, %0d evictions, %0d strings",
                 refs_sent, hits_seen, faults_seen, evictions_seen, strings_ended);
        $display("Frame limit written %0d times; %0d results checked",
                 limit_writes, results_checked);
        if (err_count == 0)
            $display("** lru_page_replacement: PASSED **");
        else
            $display("** lru_page_replacement: FAILED **");
        $finish;
    end

endmodule
